// ===== rtl/fbpa_pkg.sv =====
package fbpa_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int LINK_W     = IDX_W + 1;
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(POOL_DEPTH);

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int DIV_STEPS  = ADDR_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [1:0] KIND_ALLOC     = 2'd0;
    localparam logic [1:0] KIND_FREE      = 2'd1;
    localparam logic [1:0] KIND_TRANSLATE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [2:0] ST_MISALIGN  = 3'd4;

    localparam logic REG_BASE_ADDRESS = 1'b0;
    localparam logic REG_BLOCK_SIZE   = 1'b1;

    localparam logic [ADDR_W-1:0] BASE_RESET = '0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
    } t_in_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [IDX_W-1:0]  block_index;
        logic [ADDR_W-1:0] block_address;
    } t_out_rsp;

    typedef struct packed {
        logic load;
        logic step;
        logic rd;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic in_div;
        logic div_last;
        logic need_rd;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/fbpa_ctrl.sv =====
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_div ? S_DIV : S_CHK;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.rd = i_sts.need_rd;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/fbpa_dp.sv =====
module fbpa_dp
    import fbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  t_in_req           i_in_req,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output t_out_rsp          o_out_rsp,
    input  t_cmd              i_cmd,
    output t_sts              o_sts
);

    logic [ADDR_W-1:0]     r_base;
    logic [SIZE_W-1:0]     r_size;
    logic [LINK_W-1:0]     r_head;
    logic [1:0]            r_kind;
    logic [ADDR_W-1:0]     r_quo;
    logic [SIZE_W-1:0]     r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic [LINK_W-1:0]     r_mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] r_vld;
    logic [LINK_W-1:0]     r_rdata;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_addr;
    logic                  r_out_valid;
    t_out_rsp              r_out_rsp;

    logic [SIZE_W:0]       rem_sh;
    logic                  rem_ge;
    logic                  in_range;
    logic                  head_empty;
    logic [IDX_W-1:0]      head_idx;
    logic [IDX_W-1:0]      quo_idx;
    logic [IDX_W-1:0]      rd_addr;
    logic [LINK_W-1:0]     link_val;
    logic [ADDR_W-1:0]     alloc_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [LINK_W-1:0]     wr_data;
    logic [LINK_W-1:0]     n_head;
    t_out_rsp              n_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            r_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BASE_ADDRESS: r_base <= i_cfg_data;
                REG_BLOCK_SIZE:   r_size <= i_cfg_data[SIZE_W-1:0];
                default:          r_base <= r_base;
            endcase
        end
    end

    assign rem_sh = {r_rem, r_quo[ADDR_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_size});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_in_req.kind;
            r_quo  <= i_in_req.address - r_base;
            r_rem  <= '0;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[ADDR_W-2:0], rem_ge};
            r_rem <= rem_ge ? SIZE_W'(rem_sh - {1'b0, r_size}) : rem_sh[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign in_range   = (r_size != '0) && (r_quo < ADDR_W'(POOL_DEPTH));
    assign head_empty = (r_head >= LINK_END);
    assign head_idx   = r_head[IDX_W-1:0];
    assign quo_idx    = r_quo[IDX_W-1:0];
    assign rd_addr    = (r_kind == KIND_ALLOC) ? head_idx : quo_idx;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata   <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    assign link_val   = r_rd_vld ? r_rdata : (LINK_W'(r_rd_addr) + LINK_W'(1));
    assign alloc_addr = r_base + ADDR_W'(head_idx) * ADDR_W'(r_size);

    always_comb begin
        n_rsp   = '0;
        n_head  = r_head;
        wr_en   = 1'b0;
        wr_addr = head_idx;
        wr_data = r_head;
        case (r_kind)
            KIND_ALLOC: begin
                if (head_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.status        = ST_OK;
                    n_rsp.block_index   = head_idx;
                    n_rsp.block_address = alloc_addr;
                    n_head              = link_val;
                    wr_en               = i_cmd.commit;
                end
            end
            KIND_FREE: begin
                wr_addr = quo_idx;
                if (!in_range) begin
                    n_rsp.status = ST_RANGE;
                end else if (link_val != LINK_W'(quo_idx)) begin
                    n_rsp.status = ST_NOT_ALLOC;
                end else begin
                    n_rsp.status      = ST_OK;
                    n_rsp.block_index = quo_idx;
                    n_head            = LINK_W'(quo_idx);
                    wr_en             = i_cmd.commit;
                end
            end
            KIND_TRANSLATE: begin
                if (!in_range) begin
                    n_rsp.status = ST_RANGE;
                end else if (r_rem != '0) begin
                    n_rsp.status = ST_MISALIGN;
                end else begin
                    n_rsp.status      = ST_OK;
                    n_rsp.block_index = quo_idx;
                end
            end
            default: begin
                n_rsp.status = ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (i_cmd.commit) begin
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_rsp <= n_rsp;
        end
    end

    assign o_sts.in_div   = ((i_in_req.kind == KIND_FREE) || (i_in_req.kind == KIND_TRANSLATE))
                            && (r_size != '0);
    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.need_rd  = ((r_kind == KIND_ALLOC) && !head_empty)
                            || ((r_kind == KIND_FREE) && in_range);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

`ifndef SYNTHESIS
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LINK_END)
        else $error("free list head beyond end mark");

    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result written over an untaken result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_rsp.status != ST_OK)) |->
            ((r_out_rsp.block_index == '0) && (r_out_rsp.block_address == '0)))
        else $error("error result carries nonzero index or address");

    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_cnt == '0))
        else $error("divider count not cleared on load");
`endif

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// Fixed-size block pool allocator: a LIFO free list over POOL_DEPTH blocks.
// Request channel (i_in_valid / o_in_ready, i_in_req): kind and address.
//   Allocate pops the free list head; free and translate turn an address into
//   a block index with a bit-serial divide of (address - base) by block size.
// Response channel (o_out_valid / i_out_ready, o_out_rsp): status, index and
//   address, one response per request, in request order.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 base address, index 1
//   block size; write only while no request is in flight.
// Free and translate requests with a nonzero block size run the 32 steps of
//   the restoring divider, which retires one quotient bit per cycle; allocate
//   and the other requests skip the divider.
// One request is in flight at a time; the next is accepted once the current
//   result sits in the output register, even if it is not yet taken.
// A stalled receiver holds the result in the output register; a following
//   request runs to completion and then waits for the register to drain.
// Reset: base 0, block size 16, all blocks free with list head at block 0;
//   the link memory reads through per-entry valid bits, so no clearing pass.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_req           i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_rsp          o_out_rsp
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    fbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fbpa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_req    (i_in_req),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import fbpa_pkg::*;

    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int RUN_LIMIT     = 400000;

    class alloc_ledger;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [LINK_W-1:0] link [POOL_DEPTH];
        logic [LINK_W-1:0] head;
        t_out_rsp          awaited [$];
        int                mismatches;

        function new();
            base = BASE_RESET;
            size = SIZE_RESET;
            head = '0;
            for (int i = 0; i < POOL_DEPTH; i++) begin
                link[i] = LINK_W'(i + 1);
            end
            mismatches = 0;
        endfunction

        function void set_register(input logic idx, input logic [ADDR_W-1:0] data);
            if (idx == REG_BASE_ADDRESS) begin
                base = data;
            end else begin
                size = data[SIZE_W-1:0];
            end
        endfunction

        function bit locate(input logic [ADDR_W-1:0] addr, output logic [IDX_W-1:0] idx,
                            output bit aligned);
            logic [ADDR_W-1:0] offset;
            logic [ADDR_W-1:0] quot;
            offset  = addr - base;
            idx     = '0;
            aligned = 1'b0;
            if (size == '0) begin
                return 1'b0;
            end
            quot = offset / ADDR_W'(size);
            if (quot >= ADDR_W'(POOL_DEPTH)) begin
                return 1'b0;
            end
            idx     = quot[IDX_W-1:0];
            aligned = (offset % ADDR_W'(size)) == '0;
            return 1'b1;
        endfunction

        function void note_request(input t_in_req req);
            t_out_rsp         rsp;
            logic [IDX_W-1:0] idx;
            bit               aligned;
            rsp        = '0;
            rsp.status = ST_RANGE;
            case (req.kind)
                KIND_ALLOC: begin
                    if (head >= LINK_END) begin
                        rsp.status = ST_EMPTY;
                    end else begin
                        idx               = head[IDX_W-1:0];
                        rsp.status        = ST_OK;
                        rsp.block_index   = idx;
                        rsp.block_address = base + ADDR_W'(idx) * ADDR_W'(size);
                        head              = link[idx];
                        link[idx]         = {1'b0, idx};
                    end
                end
                KIND_FREE: begin
                    if (locate(req.address, idx, aligned)) begin
                        if (link[idx] != {1'b0, idx}) begin
                            rsp.status = ST_NOT_ALLOC;
                        end else begin
                            link[idx]       = head;
                            head            = {1'b0, idx};
                            rsp.status      = ST_OK;
                            rsp.block_index = idx;
                        end
                    end
                end
                KIND_TRANSLATE: begin
                    if (locate(req.address, idx, aligned)) begin
                        if (aligned) begin
                            rsp.status      = ST_OK;
                            rsp.block_index = idx;
                        end else begin
                            rsp.status = ST_MISALIGN;
                        end
                    end
                end
                default: begin
                end
            endcase
            awaited.push_back(rsp);
        endfunction

        function void flag(input string what, input t_out_rsp want, input t_out_rsp got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t: %s: expected status %0d index %0d address %h,",
                         $realtime, what, want.status, want.block_index, want.block_address);
                $display("    got status %0d index %0d address %h",
                         got.status, got.block_index, got.block_address);
            end
        endfunction

        function void check_response(input t_out_rsp got);
            t_out_rsp want;
            if (awaited.size() == 0) begin
                flag("response with no request outstanding", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.block_index !== want.block_index ||
                got.block_address !== want.block_address) begin
                flag("response mismatch", want, got);
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index = 1'b0;
    logic [ADDR_W-1:0] i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_req           i_in_req    = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_rsp          o_out_rsp;

    alloc_ledger ledger = new();
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_toggle    = 1'b0;
    logic        hold_seen      = 1'b0;
    int          hold_left      = 0;
    int unsigned cycle_count    = 0;

    fixed_block_pool_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_seen   <= 1'b0;
            hold_left   <= 0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen   <= hold_toggle;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            ledger.check_response(o_out_rsp);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("fixed_block_pool_allocator test failed");
            $finish;
        end
    end

    function automatic t_in_req req_of(input logic [1:0] kind, input logic [ADDR_W-1:0] address);
        t_in_req req;
        req.kind    = kind;
        req.address = address;
        return req;
    endfunction

    function automatic logic [ADDR_W-1:0] block_start(input int idx);
        return ledger.base + ADDR_W'(idx) * ADDR_W'(ledger.size);
    endfunction

    function automatic logic [ADDR_W-1:0] block_offset();
        if (ledger.size <= 1) begin
            return '0;
        end
        return ADDR_W'($urandom_range(ledger.size - 1));
    endfunction

    function automatic logic [ADDR_W-1:0] wild_address();
        case ($urandom_range(2))
            0: return $urandom();
            1: return block_start(POOL_DEPTH) + block_offset();
            default: return ledger.base - 1 - ADDR_W'($urandom_range(255));
        endcase
    endfunction

    function automatic t_in_req pick_request(input int alloc_pct);
        int                held [$];
        int                spare [$];
        int                roll;
        logic [ADDR_W-1:0] start;
        t_in_req           req;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            if (ledger.link[i] == LINK_W'(i)) begin
                held.push_back(i);
            end else begin
                spare.push_back(i);
            end
        end
        req = req_of(KIND_ALLOC, $urandom());
        if ($urandom_range(99) < alloc_pct) begin
            return req;
        end
        roll  = $urandom_range(99);
        start = block_start($urandom_range(POOL_DEPTH - 1));
        if (roll < 40 && held.size() != 0) begin
            start = block_start(held[$urandom_range(held.size() - 1)]);
            req   = req_of(KIND_FREE, start + (($urandom_range(1) == 1) ? block_offset() : '0));
        end else if (roll < 50 && spare.size() != 0) begin
            req = req_of(KIND_FREE, block_start(spare[$urandom_range(spare.size() - 1)]));
        end else if (roll < 58) begin
            req = req_of(KIND_FREE, wild_address());
        end else if (roll < 75) begin
            req = req_of(KIND_TRANSLATE, start);
        end else if (roll < 85) begin
            req = req_of(KIND_TRANSLATE, start + block_offset());
        end else if (roll < 93) begin
            req = req_of(KIND_TRANSLATE, wild_address());
        end else begin
            req = req_of(KIND_RESERVED, $urandom());
        end
        return req;
    endfunction

    task automatic send_request(input t_in_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        ledger.note_request(req);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (ledger.awaited.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        ledger.set_register(idx, data);
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                             input int send_pct, input int stall_pct, input int count,
                             input int alloc_pct, input bit long_hold, input bit mid_pause);
        wait_drained();
        write_register(REG_BASE_ADDRESS, base);
        write_register(REG_BLOCK_SIZE, ADDR_W'(size));
        i_cfg_valid    <= 1'b0;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        if (long_hold) begin
            hold_toggle <= ~hold_toggle;
        end
        for (int n = 0; n < count; n++) begin
            if (mid_pause && n == count / 2) begin
                wait_drained();
            end
            send_request(pick_request(alloc_pct));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: base 0, 16-byte blocks
        send_request(req_of(KIND_ALLOC, 32'hFFFF_FFFF));
        send_request(req_of(KIND_ALLOC, 32'h0000_0000));
        send_request(req_of(KIND_TRANSLATE, 32'd0));
        send_request(req_of(KIND_TRANSLATE, 32'd8));
        send_request(req_of(KIND_TRANSLATE, 32'd1024));
        send_request(req_of(KIND_TRANSLATE, 32'hFFFF_FFFF));
        send_request(req_of(KIND_TRANSLATE, 32'd1008));
        send_request(req_of(KIND_TRANSLATE, 32'd1023));
        send_request(req_of(KIND_FREE, 32'h15));
        send_request(req_of(KIND_FREE, 32'h10));
        send_request(req_of(KIND_FREE, 32'h20));
        send_request(req_of(KIND_FREE, 32'hFFFF_FFFF));
        send_request(req_of(KIND_FREE, 32'd1008));
        send_request(req_of(KIND_RESERVED, 32'hFFFF_FFFF));
        send_request(req_of(KIND_RESERVED, 32'h0000_0000));
        send_request(req_of(KIND_ALLOC, 32'h0));
        send_request(req_of(KIND_FREE, 32'h0));
        send_request(req_of(KIND_ALLOC, 32'h0));
        send_request(req_of(KIND_ALLOC, 32'h0));
        send_request(req_of(KIND_FREE, 32'h2F));
        send_request(req_of(KIND_FREE, 32'h2F));

        run_phase(32'h0000_0000, 16'd1, 0, 0, 140, 45, 1'b0, 1'b0);
        run_phase(32'hFFFF_FF00, 16'hFFFF, 62, 0, 140, 40, 1'b0, 1'b0);
        run_phase($urandom(), SIZE_W'($urandom_range(1, 65535)), 0, 62, 140, 40, 1'b1, 1'b0);
        // zero block size: free and translate always out of range
        run_phase(32'hFFFF_FFFF, 16'd0, 11, 11, 80, 50, 1'b0, 1'b0);
        run_phase($urandom(), SIZE_W'($urandom_range(1, 64)), 11, 11, 140, 70, 1'b0, 1'b1);
        run_phase(32'h0000_0000, 16'hFFFF, 0, 0, 60, 35, 1'b0, 1'b0);

        wait_drained();
        if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
            $display("fixed_block_pool_allocator test passed");
        end else begin
            $display("fixed_block_pool_allocator test failed");
        end
        $finish;
    end

endmodule
